[rtl/assert_macros.svh]
// assertion macros for the leg controller rtl
// depends on nothing; define ASSERT_OFF to compile the checks away
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// same-cycle implication
`define CHK_IMPLIES(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (expr)) \
        else $error("check failed");
// next-cycle implication
`define CHK_NEXT(lbl, clk, rstn, cond, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (expr)) \
        else $error("check failed");
`else
`define CHK_IMPLIES(lbl, clk, rstn, cond, expr)
`define CHK_NEXT(lbl, clk, rstn, cond, expr)
`endif
`endif

[rtl/glqr_pkg.sv]
// types, constants and helper functions of the gain scheduled leg controller
// depends on nothing
package glqr_pkg;

    localparam int NUM_LEGS_DEF = 2;
    localparam int NUM_STATES   = 6;
    localparam int PROD_W       = 67;

    localparam logic        REG_STEP_SECONDS = 1'b0;
    localparam logic        REG_STEP_RATE    = 1'b1;
    localparam logic [23:0] STEP_SECONDS_RST = 24'd16777;
    localparam logic [16:0] STEP_RATE_RST    = 17'd1000;
    localparam logic signed [17:0] HALF_PI_Q12 = 18'sd6434;

    typedef struct packed {
        logic               leg_select;
        logic [15:0]        leg_length;
        logic signed [15:0] virtual_joint_angle;
        logic signed [15:0] body_pitch;
        logic signed [15:0] pitch_rate;
        logic signed [15:0] body_velocity;
        logic signed [31:0] target_position;
        logic signed [15:0] target_velocity;
    } in_item_t;

    typedef struct packed {
        logic               leg_id;
        logic               actuator;
        logic signed [31:0] tilt_term;
        logic signed [31:0] tilt_rate_term;
        logic signed [31:0] position_term;
        logic signed [31:0] velocity_term;
        logic signed [31:0] pitch_term;
        logic signed [31:0] pitch_rate_term;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic signed [15:0] tilt;
        logic signed [31:0] pos;
    } leg_state_t;

    function automatic logic signed [31:0] sat_to32(input logic signed [PROD_W-1:0] x);
        logic signed [31:0] r;
        if (x > 67'sd2147483647)
            r = 32'sh7fffffff;
        else if (x < -67'sd2147483648)
            r = 32'sh80000000;
        else
            r = x[31:0];
        return r;
    endfunction

    function automatic logic signed [15:0] sat_to16(input logic signed [PROD_W-1:0] x);
        logic signed [15:0] r;
        if (x > 67'sd32767)
            r = 16'sh7fff;
        else if (x < -67'sd32768)
            r = 16'sh8000;
        else
            r = x[15:0];
        return r;
    endfunction

    // q16.16 alignment per state: q.12 by 13, q.10 by 11, q.16 by 17, q.11 by 12
    function automatic logic [4:0] term_shift(input logic [2:0] j);
        logic [4:0] s;
        case (j)
            3'd0:    s = 5'd13;
            3'd1:    s = 5'd11;
            3'd2:    s = 5'd17;
            3'd3:    s = 5'd12;
            3'd4:    s = 5'd13;
            3'd5:    s = 5'd11;
            default: s = 5'd0;
        endcase
        return s;
    endfunction

    // q14.17 fitted gains: wheel then joint, per gain cubic..constant
    function automatic logic signed [31:0] coef_rom(input logic [5:0] i);
        logic signed [31:0] c;
        case (i)
            6'd0:  c = -32'sd41770900;
            6'd1:  c = 32'sd42460492;
            6'd2:  c = -32'sd17962148;
            6'd3:  c = -32'sd1024731;
            6'd4:  c = -32'sd2509253;
            6'd5:  c = 32'sd2118643;
            6'd6:  c = -32'sd1725331;
            6'd7:  c = -32'sd110881;
            6'd8:  c = -32'sd7289608;
            6'd9:  c = 32'sd6621099;
            6'd10: c = -32'sd1976544;
            6'd11: c = -32'sd390843;
            6'd12: c = -32'sd4409106;
            6'd13: c = 32'sd3630899;
            6'd14: c = -32'sd1013979;
            6'd15: c = -32'sd612934;
            6'd16: c = -32'sd582999679;
            6'd17: c = 32'sd596306627;
            6'd18: c = -32'sd213000704;
            6'd19: c = 32'sd27910530;
            6'd20: c = -32'sd11431998;
            6'd21: c = 32'sd12402239;
            6'd22: c = -32'sd4896658;
            6'd23: c = 32'sd830743;
            6'd24: c = -32'sd64274761;
            6'd25: c = 32'sd69540201;
            6'd26: c = -32'sd26667254;
            6'd27: c = 32'sd4157842;
            6'd28: c = -32'sd9175092;
            6'd29: c = 32'sd9939341;
            6'd30: c = -32'sd3903497;
            6'd31: c = 32'sd577890;
            6'd32: c = -32'sd29148043;
            6'd33: c = 32'sd29776857;
            6'd34: c = -32'sd10602196;
            6'd35: c = 32'sd1368661;
            6'd36: c = -32'sd43014260;
            6'd37: c = 32'sd42786475;
            6'd38: c = -32'sd14718786;
            6'd39: c = 32'sd1820518;
            6'd40: c = 32'sd764198406;
            6'd41: c = -32'sd695503895;
            6'd42: c = 32'sd208377584;
            6'd43: c = 32'sd37157880;
            6'd44: c = 32'sd14589276;
            6'd45: c = -32'sd13693164;
            6'd46: c = 32'sd4373145;
            6'd47: c = 32'sd786927;
            default: c = 32'sd0;
        endcase
        return c;
    endfunction

endpackage

[rtl/gain_scheduled_lqr_leg_unit.sv]
// gain scheduled lqr state feedback for the legs of a wheel-legged chassis
// depends on glqr_pkg and assert_macros.svh
//
// usage
//   input channel: in_valid / in_stall / in_data, one control tick per transfer
//   output channel: out_valid / out_stall / out_data, two transfers per tick,
//   the wheel result first, then the joint result with last set
//   config: cfg_we / cfg_index / cfg_data, write only while the block is idle
//   sequencing: a tick is worked on by the single shared multiplier, and the next
//   transfer is taken only when it is done; a tick is 12 gains of three horner
//   steps (multiply, then add) plus one gain-times-error product each
//   the wheel result is offered before the joint gains are worked on
//   reset: per-leg tilt and position read as zero, registers take defaults
//   a stalled receiver holds the result register; the sequencer waits at
//   the hand-over point until the register is free
//   in_stall is high while a tick is being worked on
`include "assert_macros.svh"

module gain_scheduled_lqr_leg_unit
    import glqr_pkg::*;
#(
    parameter int NUM_LEGS = NUM_LEGS_DEF
)(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_data,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int LEG_W = (NUM_LEGS > 1) ? $clog2(NUM_LEGS) : 1;

    // one-hot sequencer
    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_READ = 10'b0000000010,
        S_RATE = 10'b0000000100,
        S_POS  = 10'b0000001000,
        S_LOAD = 10'b0000010000,
        S_HMUL = 10'b0000100000,
        S_HADD = 10'b0001000000,
        S_TMUL = 10'b0010000000,
        S_TSAT = 10'b0100000000,
        S_EMIT = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [23:0] step_seconds_reg;
    logic [16:0] step_rate_reg;

    in_item_t   item_reg;
    logic [LEG_W-1:0] leg_reg;

    // per-leg state memory, synchronous read
    leg_state_t leg_mem [NUM_LEGS];
    logic [NUM_LEGS-1:0] leg_vld_reg;
    leg_state_t rd_reg;

    logic signed [15:0] tilt_reg;
    logic signed [15:0] rate_reg;
    logic signed [31:0] err_reg [NUM_STATES];
    logic signed [31:0] term_reg [NUM_STATES];

    logic signed [33:0]       acc_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [1:0] k_reg;
    logic [2:0] j_reg;
    logic       act_reg;

    out_item_t out_reg;
    logic      out_valid_reg;

    logic accept;
    logic out_load;
    logic [LEG_W-1:0] leg_idx;
    logic [3:0] gain_idx;
    logic [5:0] coef_idx;
    logic signed [31:0] coef;

    logic signed [17:0] alpha;
    logic signed [17:0] abs_a;
    logic signed [17:0] abs_p;
    logic signed [17:0] pitch_x;
    logic signed [18:0] tilt_raw;
    logic signed [15:0] tilt_now;
    logic signed [16:0] tilt_diff;

    logic signed [33:0] pos_sum;
    logic signed [31:0] pos_new;

    logic signed [33:0] mul_a;
    logic signed [32:0] mul_b;

    assign accept   = in_valid && !in_stall;
    assign in_stall = (state_reg != S_IDLE);
    assign out_load = (state_reg == S_EMIT) && (!out_valid_reg || !out_stall);
    assign leg_idx  = (NUM_LEGS > 1) ? LEG_W'(in_data.leg_select) : '0;

    // gain number 0..11, then coefficient within the cubic
    assign gain_idx = act_reg ? (4'(j_reg) + 4'd6) : 4'(j_reg);
    assign coef_idx = {gain_idx, k_reg};
    assign coef     = coef_rom(coef_idx);

    // leg tilt from the virtual joint angle and body pitch
    always_comb
    begin
        alpha   = HALF_PI_Q12 - 18'(item_reg.virtual_joint_angle);
        pitch_x = 18'(item_reg.body_pitch);
        abs_a   = (alpha < 0) ? -alpha : alpha;
        abs_p   = (pitch_x < 0) ? -pitch_x : pitch_x;
        if ((alpha > 0 && pitch_x < 0) || (alpha < 0 && pitch_x > 0))
        begin
            tilt_raw = 19'(abs_a) - 19'(abs_p);
            if (alpha > 0)
                tilt_raw = -tilt_raw;
        end
        else
        begin
            tilt_raw = 19'(abs_a) + 19'(abs_p);
            if (!(alpha < 0 && pitch_x < 0))
                tilt_raw = -tilt_raw;
        end
        tilt_now  = sat_to16(PROD_W'(tilt_raw));
        tilt_diff = 17'(tilt_now) - 17'(rd_reg.tilt);
    end

    // position integration
    assign pos_sum = 34'(rd_reg.pos) + 34'(prod_reg >>> 19);
    assign pos_new = sat_to32(PROD_W'(pos_sum));

    // shared multiplier operand select
    always_comb
    begin
        case (state_reg)
            S_READ:
            begin
                mul_a = 34'(tilt_diff);
                mul_b = $signed(33'(step_rate_reg));
            end
            S_RATE:
            begin
                mul_a = 34'(item_reg.body_velocity);
                mul_b = $signed(33'(step_seconds_reg));
            end
            S_HMUL:
            begin
                mul_a = acc_reg;
                mul_b = $signed(33'(item_reg.leg_length));
            end
            S_TMUL:
            begin
                mul_a = 34'(err_reg[j_reg]);
                mul_b = 33'(sat_to32(PROD_W'(acc_reg)));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (accept) state_next = S_READ;
            S_READ: state_next = S_RATE;
            S_RATE: state_next = S_POS;
            S_POS:  state_next = S_LOAD;
            S_LOAD: state_next = S_HMUL;
            S_HMUL: state_next = S_HADD;
            S_HADD: state_next = (k_reg == 2'd3) ? S_TMUL : S_HMUL;
            S_TMUL: state_next = S_TSAT;
            S_TSAT: state_next = (j_reg == 3'(NUM_STATES - 1)) ? S_EMIT : S_LOAD;
            S_EMIT:
            begin
                if (out_load)
                    state_next = act_reg ? S_IDLE : S_LOAD;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            step_seconds_reg <= STEP_SECONDS_RST;
            step_rate_reg    <= STEP_RATE_RST;
            leg_vld_reg      <= '0;
            out_valid_reg    <= 1'b0;
            k_reg            <= '0;
            j_reg            <= '0;
            act_reg          <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_STEP_SECONDS: step_seconds_reg <= cfg_data;
                    REG_STEP_RATE:    step_rate_reg    <= cfg_data[16:0];
                    default:          ;
                endcase
            end
            if (state_reg == S_POS)
                leg_vld_reg[leg_reg] <= 1'b1;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
            case (state_reg)
                S_POS:
                begin
                    j_reg   <= '0;
                    act_reg <= 1'b0;
                end
                S_LOAD: k_reg <= 2'd1;
                S_HADD: if (k_reg != 2'd3) k_reg <= k_reg + 2'd1;
                // next gain starts again at its cubic coefficient
                S_TMUL: k_reg <= '0;
                S_TSAT: if (j_reg != 3'(NUM_STATES - 1)) j_reg <= j_reg + 3'd1;
                S_EMIT:
                begin
                    if (out_load)
                    begin
                        j_reg   <= '0;
                        act_reg <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    // memory read on transfer, entries never written read as zero
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= in_data;
            leg_reg  <= leg_idx;
            rd_reg   <= leg_vld_reg[leg_idx] ? leg_mem[leg_idx] : '0;
        end
    end

    // write back after the position update
    always_ff @(posedge clk)
    begin
        if (state_reg == S_POS)
            leg_mem[leg_reg] <= '{tilt: tilt_reg, pos: pos_new};
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_READ: tilt_reg <= tilt_now;
            S_RATE: rate_reg <= sat_to16(prod_reg >>> 2);
            S_POS:
            begin
                err_reg[0] <= 32'(tilt_reg);
                err_reg[1] <= 32'(rate_reg);
                err_reg[2] <= sat_to32(PROD_W'(pos_new) - PROD_W'(item_reg.target_position));
                err_reg[3] <= 32'(item_reg.body_velocity) - 32'(item_reg.target_velocity);
                err_reg[4] <= 32'(item_reg.body_pitch);
                err_reg[5] <= 32'(item_reg.pitch_rate);
            end
            S_LOAD: acc_reg <= 34'(coef);
            S_HADD: acc_reg <= 34'(prod_reg >>> 16) + 34'(coef);
            S_TSAT: term_reg[j_reg] <= sat_to32(prod_reg >>> term_shift(j_reg));
            default: ;
        endcase
    end

    // result register toward the receiver
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_reg.leg_id          <= item_reg.leg_select;
            out_reg.actuator        <= act_reg;
            out_reg.tilt_term       <= term_reg[0];
            out_reg.tilt_rate_term  <= term_reg[1];
            out_reg.position_term   <= term_reg[2];
            out_reg.velocity_term   <= term_reg[3];
            out_reg.pitch_term      <= term_reg[4];
            out_reg.pitch_rate_term <= term_reg[5];
            out_reg.last            <= act_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    `CHK_NEXT(a_accept_reads, clk, rst_n, accept, state_reg == S_READ)
    `CHK_NEXT(a_load_shows, clk, rst_n, out_load, out_valid && out_data.leg_id == item_reg.leg_select)
    `CHK_IMPLIES(a_horner_step, clk, rst_n, state_reg == S_HADD, k_reg != 2'd0)
    `CHK_IMPLIES(a_last_joint, clk, rst_n, out_valid, out_data.last == out_data.actuator)

endmodule

[verif/tb.sv]
// self-checking regression for the gain scheduled leg controller
// depends on glqr_pkg and gain_scheduled_lqr_leg_unit from the rtl folder
module tb
    import glqr_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int LIMIT = 20000;
    localparam int LATENCY = 300;

    // sign-extended wide types keep every intermediate exact
    typedef logic signed [127:0] wide_t;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_item_t    in_data;
    logic        out_valid;
    logic        out_stall;
    out_item_t   out_data;
    logic        cfg_we;
    logic        cfg_index;
    logic [23:0] cfg_data;

    gain_scheduled_lqr_leg_unit dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
        .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // predictor state: registers and per-leg memory
    logic [23:0]        period_q24;
    logic [16:0]        ticks_per_sec;
    logic signed [15:0] last_tilt [2];
    logic signed [31:0] leg_position [2];
    out_item_t          pending_results [$];

    int errors;
    int ticks_sent;
    int results_seen;
    int idle_cycles;
    int send_idle_pct;
    int recv_idle_pct;
    bit hold_off;
    bit timed_out;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic wide_t clamp(input wide_t x, input int w);
        wide_t hi;
        wide_t lo;
        hi = (wide_t'(1) <<< (w - 1)) - 1;
        lo = -hi - 1;
        if (x > hi)
            return hi;
        if (x < lo)
            return lo;
        return x;
    endfunction

    // cubic gain by horner's rule on the fitted table
    function automatic wide_t gain_at(input int base, input wide_t len);
        wide_t acc;
        acc = wide_t'(coef_rom(6'(base)));
        for (int k = 1; k < 4; k++)
            acc = ((acc * len) >>> 16) + wide_t'(coef_rom(6'(base + k)));
        return clamp(acc, 32);
    endfunction

    // leg tilt from virtual joint angle and pitch with the sign rules
    function automatic wide_t tilt_of(input wide_t phi0, input wide_t pitch);
        wide_t alpha;
        wide_t aa;
        wide_t ap;
        wide_t t;
        alpha = 6434 - phi0;
        aa = alpha < 0 ? -alpha : alpha;
        ap = pitch < 0 ? -pitch : pitch;
        if ((alpha > 0 && pitch < 0) || (alpha < 0 && pitch > 0))
        begin
            t = aa - ap;
            if (alpha > 0)
                t = -t;
        end
        else
        begin
            t = aa + ap;
            if (!(alpha < 0 && pitch < 0))
                t = -t;
        end
        return clamp(t, 16);
    endfunction

    // advance leg state and queue the wheel and joint results of one tick
    task automatic predict_tick(input in_item_t it);
        int leg;
        wide_t err [6];
        wide_t tilt;
        wide_t rate;
        wide_t pos;
        wide_t vel;
        wide_t gain;
        wide_t term;
        out_item_t r;
        int shift_of [6];
        shift_of = '{13, 11, 17, 12, 13, 11};
        leg = int'(it.leg_select) % 2;
        vel = wide_t'(it.body_velocity);
        tilt = tilt_of(wide_t'(it.virtual_joint_angle), wide_t'(it.body_pitch));
        rate = clamp(((tilt - wide_t'(last_tilt[leg])) * wide_t'(ticks_per_sec)) >>> 2, 16);
        last_tilt[leg] = tilt[15:0];
        pos = clamp(wide_t'(leg_position[leg]) + ((wide_t'(period_q24) * vel) >>> 19), 32);
        leg_position[leg] = pos[31:0];
        err[0] = tilt;
        err[1] = rate;
        err[2] = clamp(pos - wide_t'(it.target_position), 32);
        err[3] = vel - wide_t'(it.target_velocity);
        err[4] = wide_t'(it.body_pitch);
        err[5] = wide_t'(it.pitch_rate);
        for (int a = 0; a < 2; a++)
        begin
            logic signed [31:0] terms [6];
            for (int j = 0; j < 6; j++)
            begin
                gain = gain_at(a * 24 + j * 4, wide_t'({1'b0, it.leg_length}));
                term = clamp((err[j] * gain) >>> shift_of[j], 32);
                terms[j] = term[31:0];
            end
            r.leg_id = it.leg_select;
            r.actuator = 1'(a);
            r.tilt_term = terms[0];
            r.tilt_rate_term = terms[1];
            r.position_term = terms[2];
            r.velocity_term = terms[3];
            r.pitch_term = terms[4];
            r.pitch_rate_term = terms[5];
            r.last = 1'(a);
            pending_results.push_back(r);
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        errors++;
        $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $realtime);
    endtask

    // one transfer of a control tick; valid stays high across back-to-back ticks
    task automatic send_tick(input in_item_t it);
        while ($urandom_range(99, 0) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_tick(it);
        ticks_sent++;
    endtask

    task automatic end_ticks;
        in_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_drained;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
        if (idx == REG_STEP_SECONDS)
            period_q24 = val;
        else
            ticks_per_sec = val[16:0];
    endtask

    function automatic in_item_t random_tick();
        in_item_t it;
        it.leg_select          = 1'($urandom);
        // bias toward short-to-mid lengths, with full range too
        it.leg_length          = $urandom_range(3, 0) == 0 ? 16'($urandom)
                                                           : 16'($urandom_range(40000, 8000));
        it.virtual_joint_angle = $urandom_range(1, 0) ? 16'($urandom)
                                 : 16'(6434 + $signed(16'($urandom_range(4000, 0))) - 2000);
        it.body_pitch          = $urandom_range(1, 0) ? 16'($urandom)
                                 : 16'($signed(16'($urandom_range(2000, 0))) - 1000);
        it.pitch_rate          = 16'($urandom);
        it.body_velocity       = 16'($urandom);
        it.target_position     = 32'($urandom);
        it.target_velocity     = 16'($urandom);
        return it;
    endfunction

    // result checker: every accepted result against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            results_seen++;
            if (pending_results.size() == 0)
                report_mismatch("unexpected result", 32'(out_data.leg_id), 0);
            else
            begin
                out_item_t w;
                w = pending_results.pop_front();
                if (out_data.leg_id !== w.leg_id)
                    report_mismatch("leg_id", 32'(out_data.leg_id), 32'(w.leg_id));
                if (out_data.actuator !== w.actuator)
                    report_mismatch("actuator", 32'(out_data.actuator), 32'(w.actuator));
                if (out_data.tilt_term !== w.tilt_term)
                    report_mismatch("tilt_term", out_data.tilt_term, w.tilt_term);
                if (out_data.tilt_rate_term !== w.tilt_rate_term)
                    report_mismatch("tilt_rate_term", out_data.tilt_rate_term,
                                    w.tilt_rate_term);
                if (out_data.position_term !== w.position_term)
                    report_mismatch("position_term", out_data.position_term,
                                    w.position_term);
                if (out_data.velocity_term !== w.velocity_term)
                    report_mismatch("velocity_term", out_data.velocity_term,
                                    w.velocity_term);
                if (out_data.pitch_term !== w.pitch_term)
                    report_mismatch("pitch_term", out_data.pitch_term, w.pitch_term);
                if (out_data.pitch_rate_term !== w.pitch_rate_term)
                    report_mismatch("pitch_rate_term", out_data.pitch_rate_term,
                                    w.pitch_rate_term);
                if (out_data.last !== w.last)
                    report_mismatch("last", 32'(out_data.last), 32'(w.last));
            end
        end
    end

    // receiver stall: random share, plus a long hold-off when asked
    int hold_count;
    always @(posedge clk)
    begin
        if (hold_off)
        begin
            out_stall <= 1'b1;
            hold_count <= hold_count + 1;
        end
        else
        begin
            out_stall <= ($urandom_range(99, 0) < recv_idle_pct);
            hold_count <= 0;
        end
    end

    // watchdog on cycles with no transfer on either channel
    always @(posedge clk)
    begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > LIMIT && !timed_out)
        begin
            timed_out = 1'b1;
            $display("watchdog expired at %0t", $realtime);
            $display("gain_scheduled_lqr_leg_unit regression: fail");
            $finish;
        end
    end

    // directed extremes, sign-rule corners and reset defaults
    task automatic test_directed;
        in_item_t it;
        logic signed [15:0] corners [5];
        corners = '{16'sh8000, -16'sd1, 16'sd0, 16'sd6434, 16'sh7fff};
        foreach (corners[i])
        begin
            it = '0;
            it.leg_select = 1'(i);
            it.leg_length = (i % 2) ? 16'hffff : 16'h0000;
            it.virtual_joint_angle = corners[i];
            it.body_pitch = corners[4 - i];
            it.pitch_rate = corners[i];
            it.body_velocity = corners[4 - i];
            it.target_position = (i % 2) ? 32'sh7fffffff : 32'sh80000000;
            it.target_velocity = corners[i];
            send_tick(it);
        end
        // alpha and pitch each of both signs and zero
        for (int a = 0; a < 3; a++)
            for (int p = 0; p < 3; p++)
            begin
                it = random_tick();
                it.virtual_joint_angle = 16'(6434 + (a - 1) * 1500);
                it.body_pitch = 16'((p - 1) * 900);
                send_tick(it);
            end
        end_ticks();
        wait_drained();
    endtask

    // position saturation and tilt rate extremes at large, zero and unit register values
    task automatic test_register_extremes;
        in_item_t it;
        write_reg(REG_STEP_SECONDS, 24'hffffff);
        write_reg(REG_STEP_RATE, 24'd100000);
        for (int i = 0; i < 8; i++)
        begin
            it = random_tick();
            it.body_velocity = (i < 4) ? 16'sh7fff : 16'sh8000;
            send_tick(it);
        end
        end_ticks();
        wait_drained();
        // zero period and zero rate: position frozen, rate zero
        write_reg(REG_STEP_SECONDS, 24'd0);
        write_reg(REG_STEP_RATE, 24'd0);
        repeat (4) send_tick(random_tick());
        end_ticks();
        wait_drained();
        write_reg(REG_STEP_SECONDS, 24'd1);
        write_reg(REG_STEP_RATE, 24'd1);
        repeat (4) send_tick(random_tick());
        end_ticks();
        wait_drained();
    endtask

    task automatic random_phase(input int n, input int s_pct, input int r_pct);
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        write_reg(REG_STEP_SECONDS, 24'($urandom_range(40000, 1)));
        write_reg(REG_STEP_RATE, 24'($urandom_range(100000, 1)));
        repeat (n) send_tick(random_tick());
        end_ticks();
        wait_drained();
    endtask

    // hold the result register for a long stretch while ticks keep coming
    task automatic test_back_pressure;
        send_idle_pct = 0;
        hold_off = 1'b1;
        fork
            repeat (6) send_tick(random_tick());
            begin
                wait (hold_count >= 600);
                hold_off = 1'b0;
            end
        join
        end_ticks();
        wait_drained();
    endtask

    initial
    begin
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_STEP_SECONDS;
        cfg_data = '0;
        hold_off = 1'b0;
        hold_count = 0;
        timed_out = 1'b0;
        errors = 0;
        ticks_sent = 0;
        results_seen = 0;
        idle_cycles = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        period_q24 = STEP_SECONDS_RST;
        ticks_per_sec = STEP_RATE_RST;
        last_tilt = '{16'sd0, 16'sd0};
        leg_position = '{32'sd0, 32'sd0};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_register_extremes();
        random_phase(540, 23, 46);
        random_phase(540, 46, 23);
        test_back_pressure();
        random_phase(540, 0, 0);

        $display("covered %0d ticks and %0d results: sign corners, register extremes,",
                 ticks_sent, results_seen);
        $display("saturation, both legs, random idling and a long output hold-off");
        if (errors == 0 && pending_results.size() == 0)
            $display("gain_scheduled_lqr_leg_unit regression: pass");
        else
            $display("gain_scheduled_lqr_leg_unit regression: fail");
        $finish;
    end

endmodule

[files.f]
+incdir+rtl
rtl/glqr_pkg.sv
rtl/gain_scheduled_lqr_leg_unit.sv
verif/tb.sv
